@@ sv/csc_pkg.sv @@
// shared types, constants and the fault decoder for the current sensor coulomb counter
// no dependencies; every other file refers to this package by scoped names
package csc_pkg;

    localparam int unsigned ID_W      = 29;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned STAT_W    = 8;
    localparam int unsigned FNUM_W    = STAT_W - 1;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned FCODE_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // product of |current| and elapsed time, scaled down by 8, is then divided by 45
    localparam int unsigned PROD_W    = 2 * WORD_W;
    localparam int unsigned X_W       = 60;
    localparam int unsigned DIG_W     = 15;
    localparam int unsigned NUM_DIG   = X_W / DIG_W;
    localparam int unsigned REM_W     = 6;
    localparam int unsigned V_W       = REM_W + DIG_W;
    localparam int unsigned Q0_W      = 16;
    localparam int unsigned RECIP_W   = 19;
    localparam int unsigned RECIP_SH  = 24;
    localparam logic [RECIP_W-1:0] RECIP_45 = 19'd372827;
    localparam logic [REM_W-1:0]   DIV_45   = 6'd45;

    localparam int unsigned QUO_W   = 55;
    localparam int unsigned DELTA_W = QUO_W + 1;
    localparam int unsigned NEXT_W  = DELTA_W + 2;

    localparam int unsigned WQ_DEPTH = 4;
    localparam int unsigned WQ_AW    = 2;
    localparam int unsigned RQ_DEPTH = 16;
    localparam int unsigned RQ_AW    = 4;

    localparam logic [WORD_W-1:0] CUR_OFFSET = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CHARGE = 2'd2;

    localparam logic [FNUM_W-1:0] FN_FLASH_CRC     = 7'h41;
    localparam logic [FNUM_W-1:0] FN_FLUXGATE_HIGH = 7'h42;
    localparam logic [FNUM_W-1:0] FN_NO_OSC        = 7'h43;
    localparam logic [FNUM_W-1:0] FN_FAILSAFE      = 7'h44;
    localparam logic [FNUM_W-1:0] FN_NO_SIGNAL     = 7'h46;
    localparam logic [FNUM_W-1:0] FN_BRIDGE_VOLT   = 7'h47;

    localparam logic [FCODE_W-1:0] FC_FLASH_CRC     = 3'd0;
    localparam logic [FCODE_W-1:0] FC_FLUXGATE_HIGH = 3'd1;
    localparam logic [FCODE_W-1:0] FC_NO_OSC        = 3'd2;
    localparam logic [FCODE_W-1:0] FC_FAILSAFE      = 3'd3;
    localparam logic [FCODE_W-1:0] FC_NO_SIGNAL     = 3'd4;
    localparam logic [FCODE_W-1:0] FC_BRIDGE_VOLT   = 3'd5;
    localparam logic [FCODE_W-1:0] FC_OTHER         = 3'd6;
    localparam logic [FCODE_W-1:0] FC_NONE          = 3'd0;

    typedef enum logic [KIND_W-1:0] {
        KIND_IGNORED = 2'd0,
        KIND_MEAS    = 2'd1,
        KIND_FAULT   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0]   sensor_id;
        logic [WORD_W-1:0] max_charge;
    } t_cfg;

    typedef struct packed {
        t_kind                     kind;
        logic [FCODE_W-1:0]        fcode;
        logic signed [WORD_W-1:0]  cur;
        logic [WORD_W-1:0]         mag;
        logic [WORD_W-1:0]         elapsed;
    } t_work;

    typedef struct packed {
        t_kind                     kind;
        logic [FCODE_W-1:0]        fcode;
        logic signed [WORD_W-1:0]  cur;
        logic [X_W-1:0]            x;
        logic [X_W-1:0]            quo;
        logic [REM_W-1:0]          rem;
        logic [Q0_W-1:0]           q0;
    } t_div;

    typedef struct packed {
        t_kind                     kind;
        logic [FCODE_W-1:0]        fcode;
        logic signed [WORD_W-1:0]  current_ma;
        logic [WORD_W-1:0]         charge;
    } t_result;

    function automatic logic [FCODE_W-1:0] map_fault(input logic [FNUM_W-1:0] num);
        logic [FCODE_W-1:0] code;
        unique case (num)
            FN_FLASH_CRC:     code = FC_FLASH_CRC;
            FN_FLUXGATE_HIGH: code = FC_FLUXGATE_HIGH;
            FN_NO_OSC:        code = FC_NO_OSC;
            FN_FAILSAFE:      code = FC_FAILSAFE;
            FN_NO_SIGNAL:     code = FC_NO_SIGNAL;
            FN_BRIDGE_VOLT:   code = FC_BRIDGE_VOLT;
            default:          code = FC_OTHER;
        endcase
        return code;
    endfunction

endpackage

@@ sv/current_sensor_coulomb_counter_core.sv @@
// coulomb counter top level: one result per accepted frame, one frame per cycle while not full
// an accepted frame passes from the work queue through the pipeline into the result queue
// the multiply, eight divide steps and the sign stage form a non-stalling pipeline fed by credits
// synchronous active-low reset clears both queues, charge, current and the seen flag;
// registers return to sensor id 0 and max charge all ones
// depends on csc_pkg, csc_front, csc_work_q, csc_back
module current_sensor_coulomb_counter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [csc_pkg::ID_W-1:0]            i_frame_id,
    input  logic [csc_pkg::WORD_W-1:0]          i_raw_current,
    input  logic [csc_pkg::STAT_W-1:0]          i_status_byte,
    input  logic [csc_pkg::WORD_W-1:0]          i_time_ms,
    output logic                                empty,
    input  logic                                pop,
    output logic [csc_pkg::KIND_W-1:0]          o_kind,
    output logic [csc_pkg::FCODE_W-1:0]         o_fault_code,
    output logic signed [csc_pkg::WORD_W-1:0]   o_current_ma,
    output logic [csc_pkg::WORD_W-1:0]          o_charge,
    input  logic                                i_cfg_we,
    input  logic [csc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [csc_pkg::WORD_W-1:0]          i_cfg_data
);

    csc_pkg::t_cfg    r_cfg;
    csc_pkg::t_cfg    n_cfg;
    logic             load_charge;
    logic             accept;
    logic             wq_rd;
    logic             wq_empty;
    csc_pkg::t_work   front_work;
    csc_pkg::t_work   wq_head;
    csc_pkg::t_result result;

    assign accept = push && !full;

    always_comb begin
        n_cfg       = r_cfg;
        load_charge = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                csc_pkg::CFG_SENSOR_ID:    n_cfg.sensor_id  = i_cfg_data[csc_pkg::ID_W-1:0];
                csc_pkg::CFG_MAX_CHARGE:   n_cfg.max_charge = i_cfg_data;
                csc_pkg::CFG_START_CHARGE: load_charge      = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_id  <= '0;
            r_cfg.max_charge <= '1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    csc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cfg         (r_cfg),
        .i_frame_id    (i_frame_id),
        .i_raw_current (i_raw_current),
        .i_status_byte (i_status_byte),
        .i_time_ms     (i_time_ms),
        .o_work        (front_work)
    );

    csc_work_q u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (front_work),
        .i_rd    (wq_rd),
        .o_rdata (wq_head),
        .o_full  (full),
        .o_empty (wq_empty)
    );

    csc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_load_charge (load_charge),
        .i_load_value  (i_cfg_data),
        .i_work        (wq_head),
        .i_work_empty  (wq_empty),
        .o_work_rd     (wq_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result      (result)
    );

    assign o_kind       = result.kind;
    assign o_fault_code = result.fcode;
    assign o_current_ma = result.current_ma;
    assign o_charge     = result.charge;

endmodule

@@ sv/csc_front.sv @@
// front end: classifies each bus frame and works out current and elapsed time
// depends on csc_pkg
module csc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  csc_pkg::t_cfg                 i_cfg,
    input  logic [csc_pkg::ID_W-1:0]      i_frame_id,
    input  logic [csc_pkg::WORD_W-1:0]    i_raw_current,
    input  logic [csc_pkg::STAT_W-1:0]    i_status_byte,
    input  logic [csc_pkg::WORD_W-1:0]    i_time_ms,
    output csc_pkg::t_work                o_work
);

    logic [csc_pkg::WORD_W-1:0] r_last_time;
    logic [csc_pkg::WORD_W-1:0] n_last_time;
    logic                       r_seen;
    logic                       n_seen;
    logic [csc_pkg::WORD_W-1:0] cur_u;

    always_comb begin
        cur_u = i_raw_current - csc_pkg::CUR_OFFSET;
        o_work = '0;
        o_work.cur = signed'(cur_u);
        o_work.mag = cur_u[csc_pkg::WORD_W-1] ? (~cur_u + 1'b1) : cur_u;
        // first measurement counts as one millisecond
        o_work.elapsed = r_seen ? (i_time_ms - r_last_time) : csc_pkg::WORD_W'(1);
        if (i_frame_id != i_cfg.sensor_id) begin
            o_work.kind = csc_pkg::KIND_IGNORED;
        end else if (i_status_byte[0]) begin
            o_work.kind  = csc_pkg::KIND_FAULT;
            o_work.fcode = csc_pkg::map_fault(i_status_byte[csc_pkg::STAT_W-1:1]);
        end else begin
            o_work.kind = csc_pkg::KIND_MEAS;
        end
    end

    always_comb begin
        n_last_time = r_last_time;
        n_seen      = r_seen;
        if (i_accept && o_work.kind == csc_pkg::KIND_MEAS) begin
            n_last_time = i_time_ms;
            n_seen      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_seen      <= 1'b0;
        end else begin
            r_last_time <= n_last_time;
            r_seen      <= n_seen;
        end
    end

endmodule

@@ sv/csc_work_q.sv @@
// short queue of classified items between the front and back ends
// depends on csc_pkg
module csc_work_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  csc_pkg::t_work i_wdata,
    input  logic           i_rd,
    output csc_pkg::t_work o_rdata,
    output logic           o_full,
    output logic           o_empty
);

    csc_pkg::t_work             r_mem [csc_pkg::WQ_DEPTH];
    logic [csc_pkg::WQ_AW-1:0]  r_wr;
    logic [csc_pkg::WQ_AW-1:0]  r_rd;
    logic [csc_pkg::WQ_AW:0]    r_cnt;
    logic [csc_pkg::WQ_AW-1:0]  n_wr;
    logic [csc_pkg::WQ_AW-1:0]  n_rd;
    logic [csc_pkg::WQ_AW:0]    n_cnt;

    assign o_full  = (r_cnt == (csc_pkg::WQ_AW+1)'(csc_pkg::WQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    always_comb begin
        n_wr  = i_wr ? r_wr + 1'b1 : r_wr;
        n_rd  = i_rd ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (csc_pkg::WQ_AW+1)'(i_wr) - (csc_pkg::WQ_AW+1)'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

@@ sv/csc_back.sv @@
// back end: multiply, pipelined divide by 360, charge update with clamp, result queue
// depends on csc_pkg
module csc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csc_pkg::t_cfg                 i_cfg,
    input  logic                          i_load_charge,
    input  logic [csc_pkg::WORD_W-1:0]    i_load_value,
    input  csc_pkg::t_work                i_work,
    input  logic                          i_work_empty,
    output logic                          o_work_rd,
    input  logic                          i_pop,
    output logic                          o_empty,
    output csc_pkg::t_result              o_result
);

    typedef struct packed {
        csc_pkg::t_kind                     kind;
        logic [csc_pkg::FCODE_W-1:0]        fcode;
        logic signed [csc_pkg::WORD_W-1:0]  cur;
        logic [csc_pkg::DELTA_W-1:0]        delta;
    } t_fin;

    // one quotient digit estimate: (v * 2^24/45) >> 24, low by at most one
    function automatic csc_pkg::t_div step_a(input csc_pkg::t_div s);
        logic [csc_pkg::V_W-1:0]                  v;
        logic [csc_pkg::V_W+csc_pkg::RECIP_W-1:0] p;
        csc_pkg::t_div                            o;
        v = {s.rem, s.x[csc_pkg::X_W-1 -: csc_pkg::DIG_W]};
        p = (csc_pkg::V_W+csc_pkg::RECIP_W)'(v)
            * (csc_pkg::V_W+csc_pkg::RECIP_W)'(csc_pkg::RECIP_45);
        o = s;
        o.q0 = p[csc_pkg::RECIP_SH +: csc_pkg::Q0_W];
        return o;
    endfunction

    // correct the estimate and shift the digit into the quotient
    function automatic csc_pkg::t_div step_b(input csc_pkg::t_div s);
        logic [csc_pkg::V_W-1:0]  v;
        logic [csc_pkg::V_W:0]    m45;
        logic [csc_pkg::V_W:0]    r;
        logic [csc_pkg::Q0_W-1:0] q;
        csc_pkg::t_div            o;
        v   = {s.rem, s.x[csc_pkg::X_W-1 -: csc_pkg::DIG_W]};
        m45 = (csc_pkg::V_W+1)'(s.q0) * (csc_pkg::V_W+1)'(csc_pkg::DIV_45);
        r   = (csc_pkg::V_W+1)'(v) - m45;
        q   = s.q0;
        if (r >= (csc_pkg::V_W+1)'(csc_pkg::DIV_45)) begin
            r = r - (csc_pkg::V_W+1)'(csc_pkg::DIV_45);
            q = q + 1'b1;
        end
        o = s;
        o.rem = r[csc_pkg::REM_W-1:0];
        o.quo = {s.quo[csc_pkg::X_W-csc_pkg::DIG_W-1:0], q[csc_pkg::DIG_W-1:0]};
        o.x   = {s.x[csc_pkg::X_W-csc_pkg::DIG_W-1:0], csc_pkg::DIG_W'(0)};
        return o;
    endfunction

    // credits cover every slot of the result queue, so the pipeline never stalls
    logic [csc_pkg::RQ_AW:0]              r_credit;
    logic [csc_pkg::RQ_AW:0]              n_credit;
    logic                                 rq_rd;
    logic                                 rq_wr;

    logic                                 r_m_vld;
    csc_pkg::t_div                        r_m;
    csc_pkg::t_div                        n_m;
    logic [csc_pkg::PROD_W-1:0]           prod;

    logic [csc_pkg::NUM_DIG-1:0]          r_a_vld;
    logic [csc_pkg::NUM_DIG-1:0]          r_b_vld;
    logic [csc_pkg::NUM_DIG-1:0]          a_in_vld;
    csc_pkg::t_div                        r_a  [csc_pkg::NUM_DIG];
    csc_pkg::t_div                        r_b  [csc_pkg::NUM_DIG];
    csc_pkg::t_div                        a_in [csc_pkg::NUM_DIG];

    logic                                 r_d_vld;
    t_fin                                 r_d;
    t_fin                                 n_d;
    logic [csc_pkg::DELTA_W-1:0]          dmag;

    logic [csc_pkg::WORD_W-1:0]           r_charge;
    logic [csc_pkg::WORD_W-1:0]           n_charge;
    logic signed [csc_pkg::WORD_W-1:0]    r_last_cur;
    logic signed [csc_pkg::WORD_W-1:0]    n_last_cur;
    logic [csc_pkg::NEXT_W-1:0]           nxt;
    logic [csc_pkg::WORD_W-1:0]           clamped;
    csc_pkg::t_result                     res;

    csc_pkg::t_result                     r_rq [csc_pkg::RQ_DEPTH];
    logic [csc_pkg::RQ_AW-1:0]            r_rq_wr;
    logic [csc_pkg::RQ_AW-1:0]            r_rq_rd;
    logic [csc_pkg::RQ_AW:0]              r_rq_cnt;
    logic [csc_pkg::RQ_AW-1:0]            n_rq_wr;
    logic [csc_pkg::RQ_AW-1:0]            n_rq_rd;
    logic [csc_pkg::RQ_AW:0]              n_rq_cnt;

    assign o_work_rd = !i_work_empty && (r_credit != '0);
    assign o_empty   = (r_rq_cnt == '0);
    assign rq_rd     = i_pop && !o_empty;
    assign rq_wr     = r_d_vld;
    assign o_result  = r_rq[r_rq_rd];

    // multiply stage, magnitude only; floor(m/360) = floor(floor(m/8)/45)
    always_comb begin
        prod = csc_pkg::PROD_W'(i_work.mag) * csc_pkg::PROD_W'(i_work.elapsed);
        n_m = '0;
        n_m.kind  = i_work.kind;
        n_m.fcode = i_work.fcode;
        n_m.cur   = i_work.cur;
        n_m.x     = prod[csc_pkg::X_W+2:3];
    end

    always_comb begin
        a_in[0]     = r_m;
        a_in_vld[0] = r_m_vld;
        for (int j = 1; j < csc_pkg::NUM_DIG; j++) begin
            a_in[j]     = r_b[j-1];
            a_in_vld[j] = r_b_vld[j-1];
        end
    end

    // apply the sign of the current to the quotient
    always_comb begin
        dmag = {1'b0, r_b[csc_pkg::NUM_DIG-1].quo[csc_pkg::QUO_W-1:0]};
        n_d.kind  = r_b[csc_pkg::NUM_DIG-1].kind;
        n_d.fcode = r_b[csc_pkg::NUM_DIG-1].fcode;
        n_d.cur   = r_b[csc_pkg::NUM_DIG-1].cur;
        n_d.delta = r_b[csc_pkg::NUM_DIG-1].cur[csc_pkg::WORD_W-1] ? (~dmag + 1'b1) : dmag;
    end

    // charge update, the only loop-carried step
    always_comb begin
        nxt = csc_pkg::NEXT_W'(r_charge)
            - {{(csc_pkg::NEXT_W-csc_pkg::DELTA_W){r_d.delta[csc_pkg::DELTA_W-1]}}, r_d.delta};
        if (nxt[csc_pkg::NEXT_W-1]) begin
            clamped = '0;
        end else if (nxt > csc_pkg::NEXT_W'(i_cfg.max_charge)) begin
            clamped = i_cfg.max_charge;
        end else begin
            clamped = nxt[csc_pkg::WORD_W-1:0];
        end

        n_charge   = r_charge;
        n_last_cur = r_last_cur;
        res.kind       = r_d.kind;
        res.fcode      = r_d.fcode;
        res.current_ma = r_last_cur;
        res.charge     = r_charge;
        if (r_d_vld && r_d.kind == csc_pkg::KIND_MEAS) begin
            n_charge       = clamped;
            n_last_cur     = r_d.cur;
            res.current_ma = r_d.cur;
            res.charge     = clamped;
        end
        if (i_load_charge) begin
            n_charge = i_load_value;
        end
    end

    always_comb begin
        n_credit = r_credit - (csc_pkg::RQ_AW+1)'(o_work_rd) + (csc_pkg::RQ_AW+1)'(rq_rd);
        n_rq_wr  = rq_wr ? r_rq_wr + 1'b1 : r_rq_wr;
        n_rq_rd  = rq_rd ? r_rq_rd + 1'b1 : r_rq_rd;
        n_rq_cnt = r_rq_cnt + (csc_pkg::RQ_AW+1)'(rq_wr) - (csc_pkg::RQ_AW+1)'(rq_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit   <= (csc_pkg::RQ_AW+1)'(csc_pkg::RQ_DEPTH);
            r_m_vld    <= 1'b0;
            r_a_vld    <= '0;
            r_b_vld    <= '0;
            r_d_vld    <= 1'b0;
            r_charge   <= '0;
            r_last_cur <= '0;
            r_rq_wr    <= '0;
            r_rq_rd    <= '0;
            r_rq_cnt   <= '0;
        end else begin
            r_credit   <= n_credit;
            r_m_vld    <= o_work_rd;
            r_a_vld    <= a_in_vld;
            r_b_vld    <= r_a_vld;
            r_d_vld    <= r_b_vld[csc_pkg::NUM_DIG-1];
            r_charge   <= n_charge;
            r_last_cur <= n_last_cur;
            r_rq_wr    <= n_rq_wr;
            r_rq_rd    <= n_rq_rd;
            r_rq_cnt   <= n_rq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
        for (int j = 0; j < csc_pkg::NUM_DIG; j++) begin
            r_a[j] <= step_a(a_in[j]);
            r_b[j] <= step_b(r_a[j]);
        end
        r_d <= n_d;
        if (rq_wr) begin
            r_rq[r_rq_wr] <= res;
        end
    end

endmodule

@@ bench/coulomb_check.sv @@
// checker for the coulomb counter: watches the frame, result and register channels,
// predicts each result and compares it field by field; depends on csc_pkg
module coulomb_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic [csc_pkg::ID_W-1:0]            i_frame_id,
    input  logic [csc_pkg::WORD_W-1:0]          i_raw_current,
    input  logic [csc_pkg::STAT_W-1:0]          i_status_byte,
    input  logic [csc_pkg::WORD_W-1:0]          i_time_ms,
    input  logic                                empty,
    input  logic                                pop,
    input  logic [csc_pkg::KIND_W-1:0]          o_kind,
    input  logic [csc_pkg::FCODE_W-1:0]         o_fault_code,
    input  logic signed [csc_pkg::WORD_W-1:0]   o_current_ma,
    input  logic [csc_pkg::WORD_W-1:0]          o_charge,
    input  logic                                i_cfg_we,
    input  logic [csc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [csc_pkg::WORD_W-1:0]          i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_meas,
    output int                                  o_faults,
    output int                                  o_ignored,
    output int                                  o_stalls
);

    logic [csc_pkg::ID_W-1:0]           sensor_id_q;
    logic [csc_pkg::WORD_W-1:0]         max_charge_q;
    logic [csc_pkg::WORD_W-1:0]         charge_q;
    logic [csc_pkg::WORD_W-1:0]         last_time_q;
    logic                               seen_q;
    logic signed [csc_pkg::WORD_W-1:0]  last_cur_q;

    csc_pkg::t_result due_results[$];

    int n_err = 0;
    int n_pend = 0;
    int n_meas = 0;
    int n_fault = 0;
    int n_ign = 0;
    int n_stall = 0;

    assign o_errors  = n_err;
    assign o_pending = n_pend;
    assign o_meas    = n_meas;
    assign o_faults  = n_fault;
    assign o_ignored = n_ign;
    assign o_stalls  = n_stall;

    function automatic logic [csc_pkg::FCODE_W-1:0] fault_code_of(
        input logic [csc_pkg::FNUM_W-1:0] num
    );
        case (num)
            csc_pkg::FN_FLASH_CRC:     return csc_pkg::FC_FLASH_CRC;
            csc_pkg::FN_FLUXGATE_HIGH: return csc_pkg::FC_FLUXGATE_HIGH;
            csc_pkg::FN_NO_OSC:        return csc_pkg::FC_NO_OSC;
            csc_pkg::FN_FAILSAFE:      return csc_pkg::FC_FAILSAFE;
            csc_pkg::FN_NO_SIGNAL:     return csc_pkg::FC_NO_SIGNAL;
            csc_pkg::FN_BRIDGE_VOLT:   return csc_pkg::FC_BRIDGE_VOLT;
            default:                   return csc_pkg::FC_OTHER;
        endcase
    endfunction

    // advances the charge state by one frame and returns the result it gives
    function automatic csc_pkg::t_result coulomb_step(
        input logic [csc_pkg::ID_W-1:0]   fid,
        input logic [csc_pkg::WORD_W-1:0] raw,
        input logic [csc_pkg::STAT_W-1:0] stat,
        input logic [csc_pkg::WORD_W-1:0] now
    );
        csc_pkg::t_result           res;
        logic signed [csc_pkg::WORD_W-1:0] cur32;
        logic [csc_pkg::WORD_W-1:0] elapsed;
        longint                     cur;
        longint                     span;
        longint                     delta;
        longint                     nxt;
        longint                     cap;
        res.kind  = csc_pkg::KIND_IGNORED;
        res.fcode = csc_pkg::FC_NONE;
        if (fid == sensor_id_q) begin
            if (stat[0]) begin
                res.kind  = csc_pkg::KIND_FAULT;
                res.fcode = fault_code_of(stat[csc_pkg::STAT_W-1:1]);
            end else begin
                // offset binary: flipping the top bit gives the signed current
                cur32   = raw ^ csc_pkg::CUR_OFFSET;
                elapsed = seen_q ? now - last_time_q : 32'd1;
                cur     = cur32;
                span    = elapsed;
                delta   = (cur * span) / 360;
                nxt     = charge_q;
                nxt     = nxt - delta;
                cap     = max_charge_q;
                if (nxt < 0) begin
                    nxt = 0;
                end
                if (nxt > cap) begin
                    nxt = cap;
                end
                res.kind    = csc_pkg::KIND_MEAS;
                charge_q    = nxt[csc_pkg::WORD_W-1:0];
                last_cur_q  = cur32;
                last_time_q = now;
                seen_q      = 1'b1;
            end
        end
        res.current_ma = last_cur_q;
        res.charge     = charge_q;
        return res;
    endfunction

    always @(posedge i_clk) begin
        csc_pkg::t_result want;
        if (!i_rst_n) begin
            sensor_id_q  = '0;
            max_charge_q = '1;
            charge_q     = '0;
            last_time_q  = '0;
            seen_q       = 1'b0;
            last_cur_q   = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csc_pkg::CFG_SENSOR_ID:    sensor_id_q  = i_cfg_data[csc_pkg::ID_W-1:0];
                    csc_pkg::CFG_MAX_CHARGE:   max_charge_q = i_cfg_data;
                    csc_pkg::CFG_START_CHARGE: charge_q     = i_cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (due_results.size() == 0) begin
                    $error("result with no item waiting: kind %0d charge %0d", o_kind, o_charge);
                    n_err++;
                end else begin
                    want = due_results.pop_front();
                    case (want.kind)
                        csc_pkg::KIND_MEAS:  n_meas++;
                        csc_pkg::KIND_FAULT: n_fault++;
                        default:             n_ign++;
                    endcase
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind);
                        n_err++;
                    end
                    if (o_fault_code !== want.fcode) begin
                        $error("fault_code: expected %0d, got %0d", want.fcode, o_fault_code);
                        n_err++;
                    end
                    if (o_current_ma !== want.current_ma) begin
                        $error("current_ma: expected %0d, got %0d", want.current_ma,
                               o_current_ma);
                        n_err++;
                    end
                    if (o_charge !== want.charge) begin
                        $error("charge: expected %0d, got %0d", want.charge, o_charge);
                        n_err++;
                    end
                end
            end
            if (push && !full) begin
                due_results.push_back(coulomb_step(i_frame_id, i_raw_current,
                                                   i_status_byte, i_time_ms));
            end
            if (push && full) begin
                n_stall++;
            end
        end
        n_pend = due_results.size();
    end

endmodule

@@ bench/tb.sv @@
// top of the coulomb counter bench: clock, reset, frame and register stimulus, verdict
// depends on csc_pkg, current_sensor_coulomb_counter_core and coulomb_check
module tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 180;
    localparam int NUM_PHASES   = 8;
    localparam logic [csc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE = 2'd0,
        IDLE_SEND = 2'd1,
        IDLE_RECV = 2'd2,
        IDLE_BOTH = 2'd3
    } t_idle;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               push = 1'b0;
    logic                               full;
    logic [csc_pkg::ID_W-1:0]           i_frame_id = '0;
    logic [csc_pkg::WORD_W-1:0]         i_raw_current = '0;
    logic [csc_pkg::STAT_W-1:0]         i_status_byte = '0;
    logic [csc_pkg::WORD_W-1:0]         i_time_ms = '0;
    logic                               empty;
    logic                               pop = 1'b0;
    logic [csc_pkg::KIND_W-1:0]         o_kind;
    logic [csc_pkg::FCODE_W-1:0]        o_fault_code;
    logic signed [csc_pkg::WORD_W-1:0]  o_current_ma;
    logic [csc_pkg::WORD_W-1:0]         o_charge;
    logic                               i_cfg_we = 1'b0;
    logic [csc_pkg::CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [csc_pkg::WORD_W-1:0]         i_cfg_data = '0;

    int errors;
    int pending;
    int n_meas;
    int n_faults;
    int n_ignored;
    int n_stalls;

    t_idle                      idle_mode = IDLE_NONE;
    logic                       hold_req = 1'b0;
    logic                       hold_taken = 1'b0;
    int                         hold_left = 0;
    int                         cycle_cnt = 0;
    int                         n_sent = 0;
    int                         n_cfg = 0;
    logic [csc_pkg::ID_W-1:0]   sensor_cfg = '0;
    logic [csc_pkg::WORD_W-1:0] now_ms = '0;

    logic [csc_pkg::FNUM_W-1:0] known_faults [6] = '{
        csc_pkg::FN_FLASH_CRC, csc_pkg::FN_FLUXGATE_HIGH, csc_pkg::FN_NO_OSC,
        csc_pkg::FN_FAILSAFE, csc_pkg::FN_NO_SIGNAL, csc_pkg::FN_BRIDGE_VOLT
    };

    current_sensor_coulomb_counter_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_frame_id   (i_frame_id),
        .i_raw_current(i_raw_current),
        .i_status_byte(i_status_byte),
        .i_time_ms    (i_time_ms),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_fault_code (o_fault_code),
        .o_current_ma (o_current_ma),
        .o_charge     (o_charge),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    coulomb_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_frame_id   (i_frame_id),
        .i_raw_current(i_raw_current),
        .i_status_byte(i_status_byte),
        .i_time_ms    (i_time_ms),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_fault_code (o_fault_code),
        .o_current_ma (o_current_ma),
        .o_charge     (o_charge),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_meas       (n_meas),
        .o_faults     (n_faults),
        .o_ignored    (n_ignored),
        .o_stalls     (n_stalls)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver: random stalls per phase, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (idle_mode == IDLE_RECV) begin
            pop <= ($urandom_range(0, 99) >= 64);
        end else if (idle_mode == IDLE_BOTH) begin
            pop <= ($urandom_range(0, 99) >= 9);
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic bit sender_waits();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 64;
            IDLE_BOTH: return $urandom_range(0, 99) < 9;
            default:   return 1'b0;
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge with push left high
    task automatic send_frame(
        input logic [csc_pkg::ID_W-1:0]   fid,
        input logic [csc_pkg::WORD_W-1:0] raw,
        input logic [csc_pkg::STAT_W-1:0] stat,
        input logic [csc_pkg::WORD_W-1:0] t
    );
        bit taken;
        while (sender_waits()) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_frame_id    <= fid;
        i_raw_current <= raw;
        i_status_byte <= stat;
        i_time_ms     <= t;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !full;
            @(negedge i_clk);
        end
        n_sent++;
    endtask

    task automatic send_random();
        int unsigned                pick;
        int unsigned                csel;
        int unsigned                tsel;
        logic [csc_pkg::ID_W-1:0]   fid;
        logic [csc_pkg::WORD_W-1:0] raw;
        logic [csc_pkg::STAT_W-1:0] stat;
        logic [csc_pkg::FNUM_W-1:0] fnum;
        pick = $urandom_range(0, 99);
        csel = $urandom_range(0, 99);
        tsel = $urandom_range(0, 99);
        fid  = sensor_cfg;
        stat = {7'($urandom), 1'b0};
        // mostly modest currents so the charge wanders instead of pinning at a clamp
        if (csel < 70) begin
            raw = csc_pkg::CUR_OFFSET - 32'd200000 + 32'($urandom_range(0, 400000));
        end else if (csel < 90) begin
            raw = $urandom;
        end else if (csel < 94) begin
            raw = '0;
        end else if (csel < 97) begin
            raw = '1;
        end else begin
            raw = csc_pkg::CUR_OFFSET;
        end
        if (pick < 10) begin
            fid = 29'($urandom);
        end else if (pick < 24) begin
            fnum = ($urandom_range(0, 1) == 0) ? known_faults[$urandom_range(0, 5)]
                                               : 7'($urandom);
            stat = {fnum, 1'b1};
        end
        if (tsel < 4) begin
            now_ms = $urandom;
        end else if (tsel >= 8) begin
            now_ms = now_ms + 32'($urandom_range(1, 2000));
        end
        send_frame(fid, raw, stat, now_ms);
    endtask

    // sender pause until every result is back; leaves at a falling edge with push low
    task automatic drain();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(
        input logic [csc_pkg::CFG_IDX_W-1:0] idx,
        input logic [csc_pkg::WORD_W-1:0]    data
    );
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        n_cfg++;
    endtask

    initial begin
        logic [csc_pkg::ID_W-1:0]   sid;
        logic [csc_pkg::WORD_W-1:0] maxc;
        logic [csc_pkg::WORD_W-1:0] startc;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults: sensor id 0, max charge all ones, charge 0
        // first measurement counts as 1 ms, most negative current charges up
        send_frame('0, 32'h0000_0000, 8'h00, 32'd1000);
        foreach (known_faults[k]) begin
            send_frame('0, $urandom, {known_faults[k], 1'b1}, $urandom);
        end
        send_frame('0, $urandom, {7'h00, 1'b1}, $urandom);
        send_frame('0, $urandom, {7'h7F, 1'b1}, $urandom);
        send_frame('0, $urandom, {7'h45, 1'b1}, $urandom);
        send_frame('1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        // zero current with the fault number bits set but no error flag
        send_frame('0, csc_pkg::CUR_OFFSET, 8'hFE, 32'd1500);
        // full discharge runs below zero
        send_frame('0, 32'hFFFF_FFFF, 8'h00, 32'd2500);
        // huge charging step runs past the top
        send_frame('0, 32'h0000_0000, 8'h00, 32'hFFFF_FFF0);
        // timer wraps, then a repeat of the same timestamp
        send_frame('0, 32'h8000_1000, 8'h00, 32'h0000_0010);
        send_frame('0, 32'h7FFF_F000, 8'h00, 32'h0000_0010);
        drain();

        // charge loaded above the clamp stays until the next measurement
        write_reg(csc_pkg::CFG_MAX_CHARGE, 32'd1000);
        write_reg(csc_pkg::CFG_START_CHARGE, 32'd5000);
        write_reg(csc_pkg::CFG_SENSOR_ID, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_frame('0, csc_pkg::CUR_OFFSET, 8'h00, 32'd20);
        send_frame('1, $urandom, {csc_pkg::FN_FLASH_CRC, 1'b1}, 32'd30);
        send_frame('1, csc_pkg::CUR_OFFSET, 8'h00, 32'd40);
        drain();
        write_reg(csc_pkg::CFG_MAX_CHARGE, 32'd0);
        send_frame('1, 32'h0000_0000, 8'h00, 32'd50);
        send_frame('1, 32'h8000_0001, 8'h00, 32'd100);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            idle_mode = t_idle'(ph % 4);
            sid = (ph == 0) ? '1 : (ph == 1) ? '0 : 29'($urandom);
            maxc = (ph == 2) ? '1 : $urandom_range(32'd50_000_000, 32'hFFFF_FFFF);
            startc = (ph == 3) ? 32'hFFFF_FFFF : $urandom_range(0, 32'd100_000_000);
            write_reg(csc_pkg::CFG_SENSOR_ID, {3'($urandom), sid});
            write_reg(csc_pkg::CFG_MAX_CHARGE, maxc);
            write_reg(csc_pkg::CFG_START_CHARGE, startc);
            sensor_cfg = sid;
            if (ph == 0) begin
                // receiver holds off while items keep coming, so the input backs up
                hold_req = 1'b1;
                repeat (48) send_random();
                drain();
            end
            repeat (PHASE_ITEMS) send_random();
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("tb: %0d frames sent, %0d register writes, %0d cycles with input held by full",
                 n_sent, n_cfg, n_stalls);
        $display("tb: results checked: %0d measurements, %0d faults, %0d ignored",
                 n_meas, n_faults, n_ignored);
        if (errors == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
